@@ rtl/vldp_pkg.sv @@
package vldp_pkg;

    localparam int MAX_WIDTH  = 640;
    localparam int MAX_HEIGHT = 480;

    localparam int BYTE_W    = 8;
    localparam int LINE_W    = 9;
    localparam int WORD_W    = 9;
    localparam int MAP_W     = LINE_W + 1;
    localparam int LADDR_W   = 19;
    localparam int BADDR_W   = 19;
    localparam int RADDR_W   = 20;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE  = 1'b1;

    localparam logic FRAME_VGA       = 1'b0;
    localparam logic FRAME_QVGA      = 1'b1;
    localparam logic SCAN_INTERLACED = 1'b0;
    localparam logic SCAN_PROGRESS   = 1'b1;

    // geometry
    localparam logic [LINE_W-1:0] VGA_LINES  = LINE_W'(MAX_HEIGHT);
    localparam logic [LINE_W-1:0] QVGA_LINES = LINE_W'(MAX_HEIGHT / 2);
    localparam logic [LINE_W-1:0] HALF_LINES = LINE_W'(MAX_HEIGHT / 2);
    localparam logic [WORD_W-1:0] VGA_WORDS  = WORD_W'(MAX_WIDTH / 2);
    localparam logic [WORD_W-1:0] QVGA_WORDS = WORD_W'(MAX_WIDTH / 4);

    // plane bases: U follows Y (width*height bytes), V follows U (half that)
    localparam logic [RADDR_W-1:0] VGA_UBASE  = RADDR_W'(MAX_WIDTH * MAX_HEIGHT);
    localparam logic [RADDR_W-1:0] VGA_VBASE  =
        RADDR_W'(MAX_WIDTH * MAX_HEIGHT + (MAX_WIDTH * MAX_HEIGHT) / 2);
    localparam logic [RADDR_W-1:0] QVGA_UBASE =
        RADDR_W'((MAX_WIDTH / 2) * (MAX_HEIGHT / 2));
    localparam logic [RADDR_W-1:0] QVGA_VBASE =
        RADDR_W'((MAX_WIDTH / 2) * (MAX_HEIGHT / 2)
                 + ((MAX_WIDTH / 2) * (MAX_HEIGHT / 2)) / 2);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one captured word, classified and positioned by the front end
    typedef struct packed {
        logic               frame_size;
        logic [LINE_W-1:0]  frame_line;
        logic [WORD_W-1:0]  word_pos;
        logic [BYTE_W-1:0]  luma_first;
        logic [BYTE_W-1:0]  luma_second;
        logic [BYTE_W-1:0]  chroma_blue;
        logic [BYTE_W-1:0]  chroma_red;
        logic               frame_done;
    } t_job;

    typedef struct packed {
        logic push;
        logic full;
    } t_wr_side;

    typedef struct packed {
        logic pop;
        logic valid;
    } t_rd_side;

endpackage

@@ rtl/video_line_deinterlace_planarizer.sv @@
// Camera word planarizer: takes one packed Y0 U Y1 V pixel-pair word per cycle, tagged with
// its sensor line, and returns one planar YUV 4:2:2 write (Y pair address and data, U and V
// byte addresses and data) per captured word. In interlaced VGA mode the first half of the
// sensor lines land on even frame lines and the rest on odd ones. Capture starts on the line
// that maps to frame line zero and o_frame_done flags the last word of the frame; words
// outside capture or beyond the line length produce no output transaction. Throughput is
// one word per cycle unless output back-pressure fills the queue; each result passes through
// the four-entry queue and then the output register. Input ready drops only while the queue
// is full. Configuration writes take effect at once and should be issued while no
// transactions are in flight.
module video_line_deinterlace_planarizer
    import vldp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                  i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_line_start,
    input  logic [LINE_W-1:0]     i_sensor_line,
    input  logic [BYTE_W-1:0]     i_luma_first,
    input  logic [BYTE_W-1:0]     i_chroma_blue,
    input  logic [BYTE_W-1:0]     i_luma_second,
    input  logic [BYTE_W-1:0]     i_chroma_red,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [LADDR_W-1:0]    o_luma_address,
    output logic [15:0]           o_luma_pair,
    output logic [BADDR_W-1:0]    o_blue_address,
    output logic [BYTE_W-1:0]     o_blue_byte,
    output logic [RADDR_W-1:0]    o_red_address,
    output logic [BYTE_W-1:0]     o_red_byte,
    output logic                  o_frame_done
);

    t_job     w_push_job;
    t_job     w_head_job;
    t_wr_side w_wr;
    t_rd_side w_rd;
    logic     w_push;
    logic     w_pop;

    vldp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_line_start  (i_line_start),
        .i_sensor_line (i_sensor_line),
        .i_luma_first  (i_luma_first),
        .i_chroma_blue (i_chroma_blue),
        .i_luma_second (i_luma_second),
        .i_chroma_red  (i_chroma_red),
        .i_q_full      (w_wr.full),
        .o_q_push      (w_push),
        .o_job         (w_push_job)
    );

    vldp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_wr    (w_wr),
        .i_pop   (w_pop),
        .o_rd    (w_rd),
        .o_job   (w_head_job)
    );

    vldp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_rd.valid),
        .i_job          (w_head_job),
        .o_q_pop        (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_luma_address (o_luma_address),
        .o_luma_pair    (o_luma_pair),
        .o_blue_address (o_blue_address),
        .o_blue_byte    (o_blue_byte),
        .o_red_address  (o_red_address),
        .o_red_byte     (o_red_byte),
        .o_frame_done   (o_frame_done)
    );

endmodule

@@ rtl/vldp_front.sv @@
module vldp_front
    import vldp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                  i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_line_start,
    input  logic [LINE_W-1:0]     i_sensor_line,
    input  logic [BYTE_W-1:0]     i_luma_first,
    input  logic [BYTE_W-1:0]     i_chroma_blue,
    input  logic [BYTE_W-1:0]     i_luma_second,
    input  logic [BYTE_W-1:0]     i_chroma_red,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_job                  o_job
);

    logic              r_frame_size;
    logic              r_scan_mode;
    logic              r_active;
    logic [LINE_W-1:0] r_frame_line;
    logic [WORD_W-1:0] r_word_pos;

    logic              n_active;
    logic [LINE_W-1:0] n_frame_line;
    logic [WORD_W-1:0] n_word_pos;

    logic [LINE_W-1:0] w_height;
    logic [WORD_W-1:0] w_words;
    logic [MAP_W-1:0]  w_mapped;
    logic [LINE_W-1:0] w_upper;
    logic              w_accept;
    logic              w_emit;
    logic              w_done;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_height = (r_frame_size == FRAME_QVGA) ? QVGA_LINES : VGA_LINES;
    assign w_words  = (r_frame_size == FRAME_QVGA) ? QVGA_WORDS : VGA_WORDS;
    assign w_upper  = i_sensor_line - HALF_LINES;

    // interlaced VGA: first half of the sensor lines go to even lines
    always_comb begin
        if (r_frame_size == FRAME_VGA && r_scan_mode == SCAN_INTERLACED) begin
            if (i_sensor_line < HALF_LINES) begin
                w_mapped = {i_sensor_line, 1'b0};
            end else begin
                w_mapped = {w_upper, 1'b1};
            end
        end else begin
            w_mapped = {1'b0, i_sensor_line};
        end
    end

    // line start handling, before the word itself is judged
    always_comb begin
        n_active     = r_active;
        n_frame_line = r_frame_line;
        n_word_pos   = r_word_pos;
        if (i_line_start) begin
            if (w_mapped == '0) begin
                n_active     = 1'b1;
                n_frame_line = '0;
                n_word_pos   = '0;
            end else if (r_active && w_mapped < {1'b0, w_height}) begin
                n_frame_line = w_mapped[LINE_W-1:0];
                n_word_pos   = '0;
            end else if (r_active) begin
                n_word_pos = w_words;
            end
        end
    end

    assign w_emit = n_active && (n_word_pos < w_words) && (n_frame_line < w_height);
    assign w_done = (n_frame_line == w_height - LINE_W'(1))
                 && (n_word_pos == w_words - WORD_W'(1));

    assign o_q_push = w_accept && w_emit;

    always_comb begin
        o_job.frame_size  = r_frame_size;
        o_job.frame_line  = n_frame_line;
        o_job.word_pos    = n_word_pos;
        o_job.luma_first  = i_luma_first;
        o_job.luma_second = i_luma_second;
        o_job.chroma_blue = i_chroma_blue;
        o_job.chroma_red  = i_chroma_red;
        o_job.frame_done  = w_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= FRAME_QVGA;
            r_scan_mode  <= SCAN_INTERLACED;
            r_active     <= 1'b0;
            r_frame_line <= '0;
            r_word_pos   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_SIZE: r_frame_size <= i_cfg_data;
                    REG_SCAN_MODE:  r_scan_mode  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_frame_line <= n_frame_line;
                if (w_emit) begin
                    r_word_pos <= n_word_pos + WORD_W'(1);
                    r_active   <= n_active && !w_done;
                end else begin
                    r_word_pos <= n_word_pos;
                    r_active   <= n_active;
                end
            end
        end
    end

    a_done_ends_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && w_done) |=> !r_active)
        else $error("capture still active after final word");

    a_word_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_pos <= VGA_WORDS)
        else $error("word position ran past line length");

endmodule

@@ rtl/vldp_queue.sv @@
module vldp_queue
    import vldp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_job     i_job,
    output t_wr_side o_wr,
    input  logic     i_pop,
    output t_rd_side o_rd,
    output t_job     o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic w_full;
    logic w_valid;
    logic w_push;
    logic w_pop;

    assign w_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign w_valid = (r_count != '0);
    assign w_push  = i_push && !w_full;
    assign w_pop   = i_pop && w_valid;

    assign o_wr.push  = w_push;
    assign o_wr.full  = w_full;
    assign o_rd.pop   = w_pop;
    assign o_rd.valid = w_valid;
    assign o_job      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_drop_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !w_full)
        else $error("transaction pushed into full queue");

    a_ptr_count_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || w_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/vldp_back.sv @@
module vldp_back
    import vldp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_job                i_job,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [LADDR_W-1:0]  o_luma_address,
    output logic [15:0]         o_luma_pair,
    output logic [BADDR_W-1:0]  o_blue_address,
    output logic [BYTE_W-1:0]   o_blue_byte,
    output logic [RADDR_W-1:0]  o_red_address,
    output logic [BYTE_W-1:0]   o_red_byte,
    output logic                o_frame_done
);

    logic               r_valid;
    logic [LADDR_W-1:0] r_luma_address;
    logic [15:0]        r_luma_pair;
    logic [BADDR_W-1:0] r_blue_address;
    logic [BYTE_W-1:0]  r_blue_byte;
    logic [RADDR_W-1:0] r_red_address;
    logic [BYTE_W-1:0]  r_red_byte;
    logic               r_frame_done;

    logic [RADDR_W-1:0] w_line_base;
    logic [RADDR_W-1:0] w_chroma_off;
    logic [RADDR_W-1:0] w_ubase;
    logic [RADDR_W-1:0] w_vbase;
    logic [RADDR_W-1:0] w_luma_sum;

    assign o_q_pop = i_q_valid && (!r_valid || i_out_ready);

    // line*width is a constant multiply; chroma planes use half of it
    always_comb begin
        if (i_job.frame_size == FRAME_QVGA) begin
            w_line_base = RADDR_W'(i_job.frame_line * RADDR_W'(MAX_WIDTH / 2));
            w_ubase     = QVGA_UBASE;
            w_vbase     = QVGA_VBASE;
        end else begin
            w_line_base = RADDR_W'(i_job.frame_line * RADDR_W'(MAX_WIDTH));
            w_ubase     = VGA_UBASE;
            w_vbase     = VGA_VBASE;
        end
    end

    assign w_luma_sum   = w_line_base + RADDR_W'({i_job.word_pos, 1'b0});
    assign w_chroma_off = (w_line_base >> 1) + RADDR_W'(i_job.word_pos);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_luma_address <= w_luma_sum[LADDR_W-1:0];
            r_luma_pair    <= {i_job.luma_second, i_job.luma_first};
            r_blue_address <= BADDR_W'(w_ubase + w_chroma_off);
            r_blue_byte    <= i_job.chroma_blue;
            r_red_address  <= w_vbase + w_chroma_off;
            r_red_byte     <= i_job.chroma_red;
            r_frame_done   <= i_job.frame_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_luma_address = r_luma_address;
    assign o_luma_pair    = r_luma_pair;
    assign o_blue_address = r_blue_address;
    assign o_blue_byte    = r_blue_byte;
    assign o_red_address  = r_red_address;
    assign o_red_byte     = r_red_byte;
    assign o_frame_done   = r_frame_done;

endmodule
